/* src/tq_pkg.sv */
// shared types, constants and helpers for the timer queue
// no dependencies; imported by every module of the block
package tq_pkg;

  localparam int TQ_ENTRIES = 16;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_CHECK = 2'd2;

  // one stored timer
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] due;
    logic [23:0] period;
    logic        repeats;
    logic [31:0] order;
  } slot_t;

  // ordering key: due time, then age since insertion
  typedef struct packed {
    logic [31:0] due;
    logic [31:0] age;
  } key_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

/* src/tq_slot_mem.sv */
// slot storage of the timer queue: one write port, one registered read port
// depends on tq_pkg for slot_t
module tq_slot_mem import tq_pkg::*; #(
  parameter int ENTRIES = TQ_ENTRIES,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  slot_t            wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_t            rd_data
);

  slot_t mem [ENTRIES];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/tq_order_cmp.sv */
// ordering unit shared by every scan step: earlier due time, then older stamp
// depends on tq_pkg for slot_t and key_t
module tq_order_cmp import tq_pkg::*; (
  input  slot_t       cand,
  input  logic [31:0] insert_count,
  input  key_t        best_key,
  output key_t        cand_key,
  output logic        goes_first
);

  always_comb begin
    cand_key.due = cand.due;
    cand_key.age = insert_count - cand.order;
    if (cand_key.due != best_key.due) begin
      goes_first = cand_key.due < best_key.due;
    end else begin
      goes_first = cand_key.age > best_key.age;
    end
  end

endmodule

/* src/timeout_queue_one_shot_periodic.sv */
// timer queue top level: sequencer, valid bits, counters and result register
// depends on tq_pkg, tq_slot_mem and tq_order_cmp
//
// channel  dir  ports                              payload
// in       in   in_tvalid in_tready in_tdata/tuser kind, now_ms, duration_ms, periodic, timer_id
// out      out  out_tvalid out_tready out_tdata    status, new_id, fired, fired_id, fired_periodic
//
// add, clear and check sweep the slot memory one entry per cycle; out_tvalid rises
// once the sweep and then ST_FIN are done, and kind 3 goes straight to ST_FIN
// the sweep rate is set by the single read port of the slot memory
// one transaction at a time: in_tready is high only while no work or result is pending
// a stalled result holds in the output register until out_tready
// reset clears the valid bits, the id and insertion counters and all handshakes
module timeout_queue_one_shot_periodic import tq_pkg::*; #(
  parameter int ENTRIES = TQ_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // now_ms, duration_ms, periodic, timer_id, zero pad
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status, new_id, fired, fired_id, fired_periodic, zero pad
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [15:0]        next_id_r, next_id_nxt;
  logic [31:0]        ins_cnt_r, ins_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [1:0]         kind_r, kind_nxt;
  logic [31:0]        now_r, now_nxt;
  logic [23:0]        dur_r, dur_nxt;
  logic               per_r, per_nxt;
  logic [15:0]        tid_r, tid_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic               best_found_r, best_found_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  slot_t              best_r, best_nxt;
  key_t               best_key_r, best_key_nxt;

  logic               res_status_r, res_status_nxt;
  logic [15:0]        res_new_id_r, res_new_id_nxt;
  logic               res_fired_r, res_fired_nxt;
  logic [15:0]        res_fired_id_r, res_fired_id_nxt;
  logic               res_fper_r, res_fper_nxt;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  slot_t              wr_data;
  slot_t              rd_data;
  key_t               cand_key;
  logic               cand_first;
  logic [31:0]        sum_a, sum_b, sum_sat;
  logic               in_fire;

  tq_slot_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (iss_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  tq_order_cmp u_cmp (
    .cand         (rd_data),
    .insert_count (ins_cnt_r),
    .best_key     (best_key_r),
    .cand_key     (cand_key),
    .goes_first   (cand_first)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_fper_r, res_fired_id_r, res_fired_r, res_new_id_r,
                       res_status_r};

  // one saturating adder: new due time on add, rearm due time on check
  always_comb begin
    if (kind_r == KIND_ADD) begin
      sum_a = now_r;
      sum_b = {8'b0, dur_r};
    end else begin
      sum_a = best_r.due;
      sum_b = {8'b0, best_r.period};
    end
    sum_sat = sat_add32(sum_a, sum_b);
  end

  always_comb begin
    state_nxt        = state_r;
    iss_nxt          = iss_r;
    rd_vld_nxt       = 1'b0;
    valid_nxt        = valid_r;
    next_id_nxt      = next_id_r;
    ins_cnt_nxt      = ins_cnt_r;
    out_valid_nxt    = out_valid_r;
    kind_nxt         = kind_r;
    now_nxt          = now_r;
    dur_nxt          = dur_r;
    per_nxt          = per_r;
    tid_nxt          = tid_r;
    free_found_nxt   = free_found_r;
    free_idx_nxt     = free_idx_r;
    best_found_nxt   = best_found_r;
    best_idx_nxt     = best_idx_r;
    best_nxt         = best_r;
    best_key_nxt     = best_key_r;
    res_status_nxt   = res_status_r;
    res_new_id_nxt   = res_new_id_r;
    res_fired_nxt    = res_fired_r;
    res_fired_id_nxt = res_fired_id_r;
    res_fper_nxt     = res_fper_r;
    wr_en            = 1'b0;
    wr_addr          = best_idx_r;
    wr_data          = best_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          kind_nxt       = in_tuser;
          now_nxt        = in_tdata[31:0];
          dur_nxt        = in_tdata[55:32];
          per_nxt        = in_tdata[56];
          tid_nxt        = in_tdata[72:57];
          iss_nxt        = '0;
          free_found_nxt = 1'b0;
          best_found_nxt = 1'b0;
          if (in_tuser == KIND_ADD || in_tuser == KIND_CLEAR || in_tuser == KIND_CHECK) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        // issue reads; data comes back in the next cycle tagged by rd_idx_r
        if (iss_r < CNT_W'(ENTRIES)) begin
          rd_vld_nxt = 1'b1;
          iss_nxt    = iss_r + 1'b1;
        end
        if (rd_vld_r) begin
          case (kind_r)
            KIND_ADD: begin
              if (!valid_r[rd_idx_r] && !free_found_r) begin
                free_found_nxt = 1'b1;
                free_idx_nxt   = rd_idx_r;
              end
            end
            KIND_CLEAR: begin
              if (valid_r[rd_idx_r] && rd_data.id == tid_r) begin
                valid_nxt[rd_idx_r] = 1'b0;
              end
            end
            KIND_CHECK: begin
              if (valid_r[rd_idx_r] && (!best_found_r || cand_first)) begin
                best_found_nxt = 1'b1;
                best_idx_nxt   = rd_idx_r;
                best_nxt       = rd_data;
                best_key_nxt   = cand_key;
              end
            end
            default: begin
            end
          endcase
          if (rd_idx_r == IDX_W'(ENTRIES - 1)) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        res_status_nxt   = 1'b0;
        res_new_id_nxt   = '0;
        res_fired_nxt    = 1'b0;
        res_fired_id_nxt = '0;
        res_fper_nxt     = 1'b0;
        case (kind_r)
          KIND_ADD: begin
            if (free_found_r) begin
              wr_en                  = 1'b1;
              wr_addr                = free_idx_r;
              wr_data.id             = next_id_r;
              wr_data.due            = sum_sat;
              wr_data.period         = dur_r;
              wr_data.repeats        = per_r;
              wr_data.order          = ins_cnt_r;
              valid_nxt[free_idx_r]  = 1'b1;
              res_new_id_nxt         = next_id_r;
              next_id_nxt            = next_id_r + 1'b1;
              ins_cnt_nxt            = ins_cnt_r + 1'b1;
            end else begin
              res_status_nxt = 1'b1;
            end
          end
          KIND_CHECK: begin
            if (best_found_r && now_r >= best_r.due) begin
              res_fired_nxt    = 1'b1;
              res_fired_id_nxt = best_r.id;
              if (best_r.repeats) begin
                res_fper_nxt  = 1'b1;
                wr_en         = 1'b1;
                wr_addr       = best_idx_r;
                wr_data.due   = sum_sat;
                wr_data.order = ins_cnt_r;
                ins_cnt_nxt   = ins_cnt_r + 1'b1;
              end else begin
                valid_nxt[best_idx_r] = 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      valid_r     <= '0;
      next_id_r   <= '0;
      ins_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      valid_r     <= valid_nxt;
      next_id_r   <= next_id_nxt;
      ins_cnt_r   <= ins_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r          <= iss_nxt;
    rd_idx_r       <= iss_r[IDX_W-1:0];
    kind_r         <= kind_nxt;
    now_r          <= now_nxt;
    dur_r          <= dur_nxt;
    per_r          <= per_nxt;
    tid_r          <= tid_nxt;
    free_found_r   <= free_found_nxt;
    free_idx_r     <= free_idx_nxt;
    best_found_r   <= best_found_nxt;
    best_idx_r     <= best_idx_nxt;
    best_r         <= best_nxt;
    best_key_r     <= best_key_nxt;
    res_status_r   <= res_status_nxt;
    res_new_id_r   <= res_new_id_nxt;
    res_fired_r    <= res_fired_nxt;
    res_fired_id_r <= res_fired_id_nxt;
    res_fper_r     <= res_fper_nxt;
  end

`ifndef SYNTHESIS
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while a result is pending");

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r == ST_SCAN)
    else $error("slot read data returned outside a sweep");

  a_add_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && kind_r == KIND_ADD && free_found_r) |=> valid_r[$past(free_idx_r)])
    else $error("added timer not marked valid");

  a_one_add_per_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(valid_r) <= $countones($past(valid_r)) + 1)
    else $error("more than one slot filled in a cycle");
`endif

endmodule
